// File: hdl/prcr_pkg.sv
// Shared types, widths and codes for the pulse rate change reporter.
package prcr_pkg;

    localparam int WINDOW_MAX = 64;

    localparam int CNT_W      = 15;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 6;
    localparam int LEN_CFG_W  = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam int POS_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W     = $clog2(WINDOW_MAX * 32767 + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [CNT_W-1:0]      COUNTER_WRAP   = 15'h7fff;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 6'd10;
    localparam logic [LEN_CFG_W-1:0]  LENGTH_RESET   = 7'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0]  counter_reading;
        logic [TIME_W-1:0] current_time;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0]  report_count;
        logic [CNT_W-1:0]  report_average;
        logic [TIME_W-1:0] report_time;
        logic              is_backfill;
        logic              last_of_run;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic add;
        logic div_step;
        logic emit_bf;
        logic emit_main;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
        logic changed;
        logic backfill;
        logic out_free;
    } t_status;

endpackage

// File: hdl/prcr_ctrl.sv
// Sequencer for one interval word: capture, window update, divide, report.
module prcr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  prcr_pkg::t_status i_status,
    output prcr_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_CHK,
        S_BF,
        S_MAIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_status.changed) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_status.backfill) begin
                    n_state = S_BF;
                end else begin
                    n_state = S_MAIN;
                end
            end
            S_BF: begin
                if (i_status.out_free) begin
                    o_cmd.emit_bf = 1'b1;
                    n_state       = S_MAIN;
                end
            end
            S_MAIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_main = 1'b1;
                    o_cmd.commit    = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/prcr_dpath.sv
// Datapath: count delta, ring window memory, running sum, serial divider, output register.
module prcr_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prcr_pkg::t_in_word                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [prcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prcr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  prcr_pkg::t_cmd                      i_cmd,
    output prcr_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output prcr_pkg::t_out_word                 o_out_data
);

    localparam int CNT_W  = prcr_pkg::CNT_W;
    localparam int TIME_W = prcr_pkg::TIME_W;
    localparam int POS_W  = prcr_pkg::POS_W;
    localparam int FILL_W = prcr_pkg::FILL_W;
    localparam int SUM_W  = prcr_pkg::SUM_W;

    function automatic logic [FILL_W-1:0] clamp_len(input logic [prcr_pkg::LEN_CFG_W-1:0] v);
        logic [FILL_W-1:0] res;
        if (v == '0) begin
            res = FILL_W'(1);
        end else if (int'(v) > prcr_pkg::WINDOW_MAX) begin
            res = FILL_W'(prcr_pkg::WINDOW_MAX);
        end else begin
            res = FILL_W'(v);
        end
        return res;
    endfunction

    // configuration
    logic [prcr_pkg::INTERVAL_W-1:0] r_interval;
    logic [FILL_W-1:0]               r_len;
    logic                            w_len_wr;

    // window state
    logic [CNT_W-1:0]  r_mem [prcr_pkg::WINDOW_MAX];
    logic [CNT_W-1:0]  r_rd_data;
    logic [POS_W-1:0]  r_pos;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_prev;

    // per-word working registers
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_now;

    // report history
    logic [CNT_W-1:0]  r_last_count;
    logic [CNT_W-1:0]  r_last_avg;
    logic [TIME_W-1:0] r_last_time;
    logic              r_has;

    // divider
    logic [SUM_W-1:0]               r_quo;
    logic [FILL_W-1:0]              r_rem;
    logic [FILL_W-1:0]              r_div;
    logic [prcr_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic                r_out_valid;
    prcr_pkg::t_out_word r_out;

    logic [CNT_W-1:0]  w_reading;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W-1:0]  w_old;
    logic [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] w_pos_inc;
    logic [POS_W-1:0]  n_pos;
    logic [FILL_W:0]   w_shift;
    logic [FILL_W:0]   w_trial;
    logic              w_fits;
    logic [CNT_W-1:0]  w_avg;
    logic [TIME_W:0]   w_diff;
    logic              w_backfill;
    logic              w_out_free;

    assign w_len_wr = i_cfg_we && (i_cfg_index == prcr_pkg::CFG_WINDOW_LENGTH);

    assign w_reading = i_in_data.counter_reading;
    assign w_count   = (w_reading >= r_prev) ? (w_reading - r_prev)
                                             : (prcr_pkg::COUNTER_WRAP - r_prev + w_reading);

    // entries at or past the fill count were never written since the last clear
    assign w_old     = (r_fill == r_len) ? r_rd_data : '0;
    assign n_sum     = r_sum - SUM_W'(w_old) + SUM_W'(r_count);
    assign n_fill    = (r_fill < r_len) ? (r_fill + FILL_W'(1)) : r_fill;
    assign w_pos_inc = FILL_W'(r_pos) + FILL_W'(1);
    assign n_pos     = (w_pos_inc >= r_len) ? '0 : POS_W'(w_pos_inc);

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_trial = w_shift - {1'b0, r_div};
    assign w_fits  = !w_trial[FILL_W];

    assign w_avg = r_quo[CNT_W-1:0];

    assign w_diff     = {1'b0, r_now} - (TIME_W + 1)'(r_interval);
    assign w_backfill = r_has && !w_diff[TIME_W] && (r_last_time < w_diff[TIME_W-1:0]);

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status          = '0;
        o_status.div_last = (r_div_cnt == '0);
        o_status.changed  = (r_count != r_last_count) || (w_avg != r_last_avg);
        o_status.backfill = w_backfill;
        o_status.out_free = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // window memory, read port follows the write position
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_pos];
        if (i_cmd.add) begin
            r_mem[r_pos] <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= prcr_pkg::INTERVAL_RESET;
            r_len        <= clamp_len(prcr_pkg::LENGTH_RESET);
            r_pos        <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_prev       <= '0;
            r_last_count <= '0;
            r_last_avg   <= '0;
            r_last_time  <= '0;
            r_has        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == prcr_pkg::CFG_REPORT_INTERVAL)) begin
                r_interval <= i_cfg_data[prcr_pkg::INTERVAL_W-1:0];
            end
            if (w_len_wr) begin
                r_len  <= clamp_len(i_cfg_data[prcr_pkg::LEN_CFG_W-1:0]);
                r_pos  <= '0;
                r_fill <= '0;
                r_sum  <= '0;
            end else if (i_cmd.add) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (i_cmd.capture) begin
                r_prev <= w_reading;
            end
            if (i_cmd.commit) begin
                r_last_count <= r_count;
                r_last_avg   <= w_avg;
            end
            if (i_cmd.emit_main) begin
                r_last_time <= r_now;
                r_has       <= 1'b1;
            end
            if (i_cmd.emit_bf || i_cmd.emit_main) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_count <= w_count;
            r_now   <= i_in_data.current_time;
        end
        if (i_cmd.add) begin
            r_quo     <= n_sum;
            r_rem     <= '0;
            r_div     <= n_fill;
            r_div_cnt <= prcr_pkg::DIV_CNT_W'(SUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], w_fits};
            r_rem     <= w_fits ? w_trial[FILL_W-1:0] : w_shift[FILL_W-1:0];
            r_div_cnt <= r_div_cnt - prcr_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.emit_bf) begin
            r_out.report_count   <= r_last_count;
            r_out.report_average <= w_avg;
            r_out.report_time    <= w_diff[TIME_W-1:0];
            r_out.is_backfill    <= 1'b1;
            r_out.last_of_run    <= 1'b0;
        end else if (i_cmd.emit_main) begin
            r_out.report_count   <= r_count;
            r_out.report_average <= w_avg;
            r_out.report_time    <= r_now;
            r_out.is_backfill    <= 1'b0;
            r_out.last_of_run    <= 1'b1;
        end
    end

endmodule

// File: hdl/pulse_rate_change_reporter.sv
// Top level: pulse rate change reporter, controller plus datapath.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one word per sampling
//   interval, carrying the raw 15-bit wrapping counter reading and the time.
//   Output channel (o_out_valid / i_out_stall / o_out_data): zero, one or two
//   report words per input word; a backfill word, when present, comes first,
//   and last_of_run marks the final word of that input.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): index 0 is the report
//   interval, index 1 the window length; writing the length empties the window.
// Timing: an input word is captured in the idle state and the window updated in
//   the add state, then the serial divider of the 21-bit window sum by the fill
//   count runs one quotient bit per cycle, then a compare state, then one report
//   state per report word, each waiting while the output word is held.
//   The next word is taken once the last report is in the output register.
// Reset: synchronous, active low; window empty, no report history, interval 10,
//   length 6. A stalled receiver holds the output word and the block waits
//   before loading the next report.
module pulse_rate_change_reporter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  prcr_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output prcr_pkg::t_out_word             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [prcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    prcr_pkg::t_cmd    w_cmd;
    prcr_pkg::t_status w_status;

    prcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    prcr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_bf_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_bf |=> o_out_valid && o_out_data.is_backfill && !o_out_data.last_of_run)
        else $error("backfill report not loaded as expected");

    a_main_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_main |=> o_out_valid && o_out_data.last_of_run && !o_out_data.is_backfill)
        else $error("main report not loaded as expected");

    a_not_last_is_bf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_run |-> o_out_data.is_backfill)
        else $error("non-final report word is not a backfill");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_bf || w_cmd.emit_main) |-> (!o_out_valid || !i_out_stall))
        else $error("report loaded over a held output word");
`endif

endmodule

// File: tb/prcr_report_checker.sv
// Report checker: predicts report words from accepted input words and compares them.
module prcr_report_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  prcr_pkg::t_in_word                i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  prcr_pkg::t_out_word               i_out_data,
    input  logic                              i_cfg_we,
    input  logic [prcr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prcr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_report_words,
    output int                                o_backfill_words
);
    timeunit 1ns;
    timeprecision 1ps;

    prcr_pkg::t_out_word expected_reports[$];

    // predictor state
    logic [prcr_pkg::INTERVAL_W-1:0] interval;
    int unsigned                     win_len;
    logic [prcr_pkg::CNT_W-1:0]      prev_reading;
    logic [prcr_pkg::CNT_W-1:0]      count_ring [prcr_pkg::WINDOW_MAX];
    int unsigned                     wr_pos;
    int unsigned                     fill;
    int unsigned                     ring_sum;
    logic [prcr_pkg::CNT_W-1:0]      last_cnt;
    logic [prcr_pkg::CNT_W-1:0]      last_avg;
    logic [prcr_pkg::TIME_W-1:0]     last_time;
    bit                              reported;

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
            note_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endtask

    task automatic empty_ring();
        foreach (count_ring[k]) count_ring[k] = '0;
        wr_pos   = 0;
        fill     = 0;
        ring_sum = 0;
    endtask

    function automatic prcr_pkg::t_out_word make_report(
        input logic [prcr_pkg::CNT_W-1:0]  cnt,
        input logic [prcr_pkg::CNT_W-1:0]  avg,
        input logic [prcr_pkg::TIME_W-1:0] stamp,
        input logic                        backfill);
        prcr_pkg::t_out_word r;
        r.report_count   = cnt;
        r.report_average = avg;
        r.report_time    = stamp;
        r.is_backfill    = backfill;
        r.last_of_run    = !backfill;
        return r;
    endfunction

    task automatic predict_reports(input prcr_pkg::t_in_word w);
        logic [prcr_pkg::CNT_W-1:0]  cnt;
        logic [prcr_pkg::CNT_W-1:0]  avg;
        logic [prcr_pkg::TIME_W-1:0] now;
        int unsigned                 pos;
        now = w.current_time;
        if (w.counter_reading >= prev_reading)
            cnt = w.counter_reading - prev_reading;
        else
            cnt = prcr_pkg::COUNTER_WRAP - prev_reading + w.counter_reading;
        prev_reading = w.counter_reading;

        pos = (wr_pos >= prcr_pkg::WINDOW_MAX) ? 0 : wr_pos;
        ring_sum = ring_sum - count_ring[pos] + cnt;
        count_ring[pos] = cnt;
        pos++;
        wr_pos = (pos >= win_len) ? 0 : pos;
        if (fill < win_len) fill++;
        avg = (fill != 0) ? prcr_pkg::CNT_W'(ring_sum / fill) : '0;

        if (cnt != last_cnt || avg != last_avg) begin
            // backfill only when the previous report is older than one interval
            if (reported && now >= interval && last_time < now - interval)
                expected_reports.push_back(make_report(last_cnt, avg, now - interval, 1'b1));
            expected_reports.push_back(make_report(cnt, avg, now, 1'b0));
            last_time = now;
            reported  = 1'b1;
        end
        last_cnt = cnt;
        last_avg = avg;
    endtask

    always @(posedge i_clk) begin
        prcr_pkg::t_out_word want;
        if (!i_rst_n) begin
            interval     = prcr_pkg::INTERVAL_RESET;
            win_len      = 32'(prcr_pkg::LENGTH_RESET);
            prev_reading = '0;
            last_cnt     = '0;
            last_avg     = '0;
            last_time    = '0;
            reported     = 1'b0;
            empty_ring();
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == prcr_pkg::CFG_REPORT_INTERVAL) begin
                    interval = i_cfg_data[prcr_pkg::INTERVAL_W-1:0];
                end else if (i_cfg_index == prcr_pkg::CFG_WINDOW_LENGTH) begin
                    if (i_cfg_data == 0)
                        win_len = 1;
                    else if (i_cfg_data > prcr_pkg::WINDOW_MAX)
                        win_len = prcr_pkg::WINDOW_MAX;
                    else
                        win_len = 32'(i_cfg_data);
                    empty_ring();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_report_words++;
                if (i_out_data.is_backfill) o_backfill_words++;
                if (expected_reports.size() == 0) begin
                    note_mismatch($sformatf("report word 0x%0h with nothing expected",
                                            i_out_data));
                end else begin
                    want = expected_reports.pop_front();
                    check_field("report_count", want.report_count, i_out_data.report_count);
                    check_field("report_average", want.report_average,
                                i_out_data.report_average);
                    check_field("report_time", want.report_time, i_out_data.report_time);
                    check_field("is_backfill", want.is_backfill, i_out_data.is_backfill);
                    check_field("last_of_run", want.last_of_run, i_out_data.last_of_run);
                end
            end
            if (i_in_valid && !i_in_stall) predict_reports(i_in_data);
        end
        o_pending <= expected_reports.size();
    end

endmodule

// File: tb/pulse_rate_change_reporter_tb.sv
// Testbench top: stimulus, config writes, idling and verdict for the rate change reporter.
module pulse_rate_change_reporter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCKS          = 17;
    localparam int WORDS_PER_BLOCK = 50;
    localparam int SETTLE_CYCLES   = 60;
    localparam int CYCLE_LIMIT     = 500_000;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    prcr_pkg::t_in_word              i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    prcr_pkg::t_out_word             o_out_data;
    logic                            i_cfg_we    = 1'b0;
    logic [prcr_pkg::CFG_IDX_W-1:0]  i_cfg_index = prcr_pkg::CFG_REPORT_INTERVAL;
    logic [prcr_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    int mismatches;
    int pending;
    int report_words;
    int backfill_words;

    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          words_sent    = 0;
    int          settings_made = 0;
    int unsigned cycle_count   = 0;

    // generator state for the random part
    logic [prcr_pkg::CNT_W-1:0]  cur_reading = '0;
    logic [prcr_pkg::CNT_W-1:0]  last_delta  = '0;
    logic [prcr_pkg::TIME_W-1:0] cur_time    = '0;
    int unsigned                 step        = 10;

    pulse_rate_change_reporter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    prcr_report_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out_data       (o_out_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_report_words   (report_words),
        .o_backfill_words (backfill_words)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pulse_rate_change_reporter_tb NOT OK");
        $finish;
    end

    function automatic prcr_pkg::t_in_word word_of(
        input logic [prcr_pkg::CNT_W-1:0]  reading,
        input logic [prcr_pkg::TIME_W-1:0] stamp);
        prcr_pkg::t_in_word w;
        w.counter_reading = reading;
        w.current_time    = stamp;
        return w;
    endfunction

    // valid stays high after acceptance; settle() or an idle gap in the next call lowers it
    task automatic send_word(input prcr_pkg::t_in_word w);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // stop sending, wait for all reports, then cover words that report nothing
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [prcr_pkg::CFG_DATA_W-1:0] ivl,
                                  input logic [prcr_pkg::CFG_DATA_W-1:0] len,
                                  input bit write_len);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= prcr_pkg::CFG_REPORT_INTERVAL;
        i_cfg_data  <= ivl;
        @(posedge i_clk);
        if (write_len) begin
            i_cfg_index <= prcr_pkg::CFG_WINDOW_LENGTH;
            i_cfg_data  <= len;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        step = 32'(ivl[prcr_pkg::INTERVAL_W-1:0]);
        settings_made++;
    endtask

    task automatic make_sample(output prcr_pkg::t_in_word w);
        int unsigned                pick;
        logic [prcr_pkg::CNT_W-1:0] delta;
        delta = last_delta;
        pick  = $urandom_range(0, 99);
        // repeated deltas give steady rates, so some words report nothing
        if (pick >= 40 && pick < 80)
            delta = prcr_pkg::CNT_W'($urandom_range(0, 60));
        else if (pick >= 80 && pick < 92)
            delta = prcr_pkg::CNT_W'($urandom_range(0, 32767));
        if (pick < 92)
            cur_reading = cur_reading + delta;
        else if (pick < 96)
            cur_reading = prcr_pkg::CNT_W'($urandom_range(0, 32767));
        else
            cur_reading = (pick[0]) ? prcr_pkg::COUNTER_WRAP : '0;
        last_delta = delta;

        pick = $urandom_range(0, 99);
        if (pick < 50)
            cur_time = cur_time + step;
        else if (pick < 75)
            cur_time = cur_time + $urandom_range(0, 2 * step + 1);
        else if (pick < 90)
            cur_time = cur_time + $urandom_range(0, 3);
        else if (pick < 97)
            cur_time = $urandom;
        else if (pick < 99)
            cur_time = 32'hffff_ffff - $urandom_range(0, 3);
        else
            cur_time = $urandom_range(0, 3);
        w = word_of(cur_reading, cur_time);
    endtask

    initial begin
        prcr_pkg::t_in_word              w;
        logic [prcr_pkg::CFG_DATA_W-1:0] ivl;
        logic [prcr_pkg::CFG_DATA_W-1:0] len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: interval 10, length 6
        send_word(word_of(15'd0, 32'd0));        // first pair (0,0): nothing reported
        send_word(word_of(15'd0, 32'd5));
        send_word(word_of(15'd600, 32'd20));     // first report, no history for backfill
        send_word(word_of(15'd600, 32'd30));
        send_word(word_of(15'd600, 32'd55));     // last report too old: backfill first
        send_word(word_of(15'd100, 32'd60));     // counter wrap
        send_word(word_of(15'h7fff, 32'd61));
        send_word(word_of(15'h7fff, 32'd62));

        // interval zero, length 0 acts as 1
        apply_settings(7'd0, 7'd0, 1'b1);
        send_word(word_of(15'h7fff, 32'd100));
        send_word(word_of(15'd5, 32'd101));
        send_word(word_of(15'd10, 32'd101));     // steady rate: unchanged pair
        send_word(word_of(15'd15, 32'd102));
        send_word(word_of(15'd25, 32'd110));
        send_word(word_of(15'd0, 32'hffff_ffff));

        // widest interval, length above the window maximum
        apply_settings(7'd63, 7'd127, 1'b1);
        send_word(word_of(15'd1000, 32'd10));    // time below interval: no backfill
        send_word(word_of(15'd1000, 32'd20));
        send_word(word_of(15'd2000, 32'd200));
        send_word(word_of(15'd2000, 32'd300));
        send_word(word_of(15'h7fff, 32'hffff_fff0));
        cur_reading = 15'h7fff;
        cur_time    = 32'hffff_fff0;

        for (int blk = 0; blk < BLOCKS; blk++) begin
            case (blk % 6)
                0:       ivl = 7'd63;
                1:       ivl = 7'd0;
                2:       ivl = 7'd1;
                3:       ivl = 7'h46;            // upper bit is dropped
                default: ivl = prcr_pkg::CFG_DATA_W'($urandom_range(2, 20));
            endcase
            case (blk % 5)
                0:       len = 7'd1;
                1:       len = 7'd127;
                2:       len = prcr_pkg::CFG_DATA_W'(prcr_pkg::WINDOW_MAX);
                3:       len = 7'd0;
                default: len = prcr_pkg::CFG_DATA_W'($urandom_range(2, 12));
            endcase
            apply_settings(ivl, len, (blk % 4) != 3);
            if (blk < 6) begin
                in_idle_pct   = 7;
                out_stall_pct = 71;
            end else if (blk < 12) begin
                in_idle_pct   = 71;
                out_stall_pct = 7;
            end else begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
                if (blk == 8 && k == WORDS_PER_BLOCK / 2) settle();
                make_sample(w);
                send_word(w);
            end
        end

        settle();
        $display("sent %0d input words across %0d register settings", words_sent,
                 settings_made);
        $display("checked %0d report words, %0d of them backfill", report_words,
                 backfill_words);
        if (mismatches == 0)
            $display("pulse_rate_change_reporter_tb OK");
        else
            $display("pulse_rate_change_reporter_tb NOT OK");
        $finish;
    end

endmodule
